@@ hdl/pbrd_pkg.sv @@
// ----------------------------------------------------------------------------
// pbrd_pkg
// Shared types and constants for the PackBits run-length decoder.
// ----------------------------------------------------------------------------
package pbrd_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = 3;
    localparam int LIT_W   = 7;
    localparam int LANES   = WORD_W / BYTE_W;

    // header code that means no operation
    localparam logic [BYTE_W-1:0] HDR_NOP = 8'h80;

    // input word
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              block_last;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [CNT_W-1:0]  byte_count;
        logic              run_end;
        logic              block_end;
        logic              truncated;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;   // take the input word and set up its results
        logic emit;   // move the next result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic has_work;   // results still owed for the current word
        logic slot_free;  // output register can take a result this cycle
    } t_dp_sts;

endpackage

@@ hdl/packbits_rle_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// packbits_rle_decoder_unit
// PackBits decoder: one compressed byte in, packed decoded words out.
// ----------------------------------------------------------------------------
// One compressed byte is taken, then the input stalls until all of its output
// words have been moved into the output register. A header byte yields no word
// (only the truncation word if block_last ends a packet early); a literal byte
// yields one word (two with truncation); a repeat value byte that expands to n
// copies yields ceil(n/4) words, up to 32 for 128 copies. The sequencer takes
// the byte, moves each word through the single output register and then
// returns to idle, and any stall on the output side holds it. Repeat copies are
// packed four to a word, first copy in bits 7:0, unused bytes zero.
module packbits_rle_decoder_unit
    import pbrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer
    pbrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // decode state and output register
    pbrd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

@@ hdl/pbrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbrd_ctrl
// Sequencer: takes one input word, then drives emission of its results.
// ----------------------------------------------------------------------------
module pbrd_ctrl
    import pbrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;
    logic   r_stall;
    logic   w_accept;

    // input word taken only while idle
    assign w_accept = i_valid && !r_stall;

    // commands to the datapath
    always_comb begin
        o_cmd.load = w_accept;
        o_cmd.emit = (r_state == ST_RUN) && i_sts.has_work && i_sts.slot_free;
    end

    assign o_stall = r_stall;

    // state and registered stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stall <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RUN;
                        r_stall <= 1'b1;
                    end
                end
                ST_RUN: begin
                    if (!i_sts.has_work) begin
                        r_state <= ST_IDLE;
                        r_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_stall <= 1'b0;
                end
            endcase
        end
    end

endmodule

@@ hdl/pbrd_datapath.sv @@
// ----------------------------------------------------------------------------
// pbrd_datapath
// Packet state, pending result counters and the output register.
// ----------------------------------------------------------------------------
module pbrd_datapath
    import pbrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LITERAL,
        PH_REPEAT,
        PH_UNUSED
    } t_phase;

    // packet state
    t_phase            r_phase;
    logic [LIT_W-1:0]  r_lit_left;
    logic [BYTE_W-1:0] r_rep_count;

    // current word being emitted
    logic [BYTE_W-1:0] r_val;
    logic              r_last;
    logic [BYTE_W-1:0] r_left;
    logic              r_trunc_pend;

    // output register
    logic              r_out_valid;
    t_out_word         r_out;

    // next values on load
    t_phase            n_phase;
    logic [LIT_W-1:0]  n_lit_left;
    logic [BYTE_W-1:0] n_rep_count;
    logic [BYTE_W-1:0] n_left;
    logic              n_trunc_pend;

    // next result
    logic [CNT_W-1:0]  w_chunk;
    logic [BYTE_W-1:0] w_left_after;
    logic [WORD_W-1:0] w_word;
    t_out_word         n_out;

    // decode the input word against the packet state
    always_comb begin
        n_phase      = r_phase;
        n_lit_left   = r_lit_left;
        n_rep_count  = r_rep_count;
        n_left       = '0;
        n_trunc_pend = 1'b0;
        unique case (r_phase)
            PH_LITERAL: begin
                n_left = BYTE_W'(1);
                if (r_lit_left != '0) begin
                    n_lit_left   = r_lit_left - LIT_W'(1);
                    n_trunc_pend = i_in_word.block_last;
                end else begin
                    n_phase = PH_HEADER;
                end
            end
            PH_REPEAT: begin
                n_left      = r_rep_count;
                n_phase     = PH_HEADER;
                n_rep_count = '0;
            end
            default: begin
                if (!i_in_word.in_byte[BYTE_W-1]) begin
                    n_lit_left   = i_in_word.in_byte[LIT_W-1:0];
                    n_phase      = PH_LITERAL;
                    n_trunc_pend = i_in_word.block_last;
                end else if (i_in_word.in_byte != HDR_NOP) begin
                    // two's complement negate plus one gives 1 - h
                    n_rep_count  = BYTE_W'(~i_in_word.in_byte) + BYTE_W'(2);
                    n_phase      = PH_REPEAT;
                    n_trunc_pend = i_in_word.block_last;
                end else begin
                    n_phase = PH_HEADER;
                end
            end
        endcase
        // block end returns to the reset state
        if (i_in_word.block_last) begin
            n_phase     = PH_HEADER;
            n_lit_left  = '0;
            n_rep_count = '0;
        end
    end

    // next result: up to four copies, or the truncation marker
    always_comb begin
        w_chunk      = (r_left > BYTE_W'(LANES)) ? CNT_W'(LANES) : CNT_W'(r_left);
        w_left_after = r_left - BYTE_W'(w_chunk);
        for (int i = 0; i < LANES; i++) begin
            w_word[i*BYTE_W +: BYTE_W] = (CNT_W'(i) < w_chunk) ? r_val : '0;
        end
        if (r_left != '0) begin
            n_out.data_word  = w_word;
            n_out.byte_count = w_chunk;
            n_out.run_end    = (w_left_after == '0) && !r_trunc_pend;
            n_out.block_end  = r_last;
            n_out.truncated  = 1'b0;
        end else begin
            n_out.data_word  = '0;
            n_out.byte_count = '0;
            n_out.run_end    = 1'b1;
            n_out.block_end  = 1'b1;
            n_out.truncated  = 1'b1;
        end
    end

    // status
    always_comb begin
        o_sts.has_work  = (r_left != '0) || r_trunc_pend;
        o_sts.slot_free = !r_out_valid || !i_out_stall;
    end

    // packet state and emission counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_lit_left   <= '0;
            r_rep_count  <= '0;
            r_left       <= '0;
            r_trunc_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_phase      <= n_phase;
            r_lit_left   <= n_lit_left;
            r_rep_count  <= n_rep_count;
            r_left       <= n_left;
            r_trunc_pend <= n_trunc_pend;
        end else if (i_cmd.emit) begin
            if (r_left != '0) begin
                r_left <= w_left_after;
            end else begin
                r_trunc_pend <= 1'b0;
            end
        end
    end

    // value byte and block flag of the current word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= i_in_word.in_byte;
            r_last <= i_in_word.block_last;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
